// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_PRIORITY_BITS = 8;
    localparam int DEF_DATA_BITS     = 32;

    localparam int STATUS_BITS = 2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_PUSH_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_POP_EMPTY  = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
    } spq_ctrl_t;

endpackage

// ===== rtl/core/spq_req_if.sv =====
interface spq_req_if #(
    parameter int DATA_BITS     = 32,
    parameter int PRIORITY_BITS = 8
);
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [DATA_BITS-1:0]     item_data;
    logic [PRIORITY_BITS-1:0] item_priority;

    modport source (output valid, output cmd, output item_data, output item_priority,
                    input ready);
    modport sink   (input valid, input cmd, input item_data, input item_priority,
                    output ready);
endinterface

// ===== rtl/core/spq_rsp_if.sv =====
interface spq_rsp_if #(
    parameter int DATA_BITS     = 32,
    parameter int PRIORITY_BITS = 8,
    parameter int COUNT_BITS    = 5
);
    logic                     valid;
    logic                     ready;
    logic                     popped_valid;
    logic [DATA_BITS-1:0]     popped_data;
    logic [PRIORITY_BITS-1:0] popped_priority;
    logic [1:0]               status;
    logic                     queue_empty;
    logic [DATA_BITS-1:0]     head_data;
    logic [COUNT_BITS-1:0]    entry_count;

    modport source (output valid, output popped_valid, output popped_data,
                    output popped_priority, output status, output queue_empty,
                    output head_data, output entry_count, input ready);
    modport sink   (input valid, input popped_valid, input popped_data,
                    input popped_priority, input status, input queue_empty,
                    input head_data, input entry_count, output ready);
endinterface

// ===== rtl/core/sorted_priority_queue.sv =====
// Sorted min-first priority queue built as a row of compare-and-shift cells.
// The result is registered when the item is accepted and held while the output stalls.
// Throughput: one push or pop per cycle while the result side keeps ready high; every
// cell compares against the new priority and shifts with its neighbor in the same cycle.
// Reset: entry count and output valid clear; cell contents are left as is.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
    parameter int DATA_BITS     = DEF_DATA_BITS,
    parameter int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  accept;
    logic                  full;
    logic                  empty;
    spq_ctrl_t             ctrl;

    logic                     out_valid_reg;
    logic                     popped_valid_reg;
    logic [DATA_BITS-1:0]     popped_data_reg;
    logic [PRIORITY_BITS-1:0] popped_prio_reg;
    logic [1:0]               status_reg;
    logic                     queue_empty_reg;
    logic [DATA_BITS-1:0]     head_data_reg;
    logic [COUNT_BITS-1:0]    entry_count_reg;

    logic [DATA_BITS-1:0]     cell_data      [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] cell_prio      [QUEUE_DEPTH];
    logic [DATA_BITS-1:0]     cell_data_next [QUEUE_DEPTH];
    logic                     cell_keep      [QUEUE_DEPTH];

    assign full   = (count_reg == COUNT_BITS'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign accept = req.valid && req.ready;
    assign req.ready = !out_valid_reg || rsp.ready;

    assign ctrl.push = accept && (req.cmd == CMD_PUSH) && !full;
    assign ctrl.pop  = accept && (req.cmd == CMD_POP) && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
            count_next = count_reg + 1'b1;
        else if (ctrl.pop)
            count_next = count_reg - 1'b1;
    end

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic                     occ;
            logic                     left_keep;
            logic [DATA_BITS-1:0]     left_data;
            logic [PRIORITY_BITS-1:0] left_prio;
            logic [DATA_BITS-1:0]     right_data;
            logic [PRIORITY_BITS-1:0] right_prio;

            assign occ = (count_reg > COUNT_BITS'(i));

            if (i == 0)
            begin : g_first
                assign left_keep = 1'b1;
                assign left_data = req.item_data;
                assign left_prio = req.item_priority;
            end
            else
            begin : g_mid
                assign left_keep = cell_keep[i-1];
                assign left_data = cell_data[i-1];
                assign left_prio = cell_prio[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_data = cell_data[i];
                assign right_prio = cell_prio[i];
            end
            else
            begin : g_inner
                assign right_data = cell_data[i+1];
                assign right_prio = cell_prio[i+1];
            end

            spq_cell #(
                .DATA_BITS     (DATA_BITS),
                .PRIORITY_BITS (PRIORITY_BITS)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occ        (occ),
                .left_keep  (left_keep),
                .left_data  (left_data),
                .left_prio  (left_prio),
                .right_data (right_data),
                .right_prio (right_prio),
                .new_data   (req.item_data),
                .new_prio   (req.item_priority),
                .keep       (cell_keep[i]),
                .data       (cell_data[i]),
                .prio       (cell_prio[i]),
                .data_next  (cell_data_next[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_valid_reg <= ctrl.pop;
            popped_data_reg  <= ctrl.pop ? cell_data[0] : '0;
            popped_prio_reg  <= ctrl.pop ? cell_prio[0] : '0;
            if (req.cmd == CMD_PUSH)
                status_reg <= full ? STATUS_PUSH_FULL : STATUS_OK;
            else
                status_reg <= empty ? STATUS_POP_EMPTY : STATUS_OK;
            queue_empty_reg <= (count_next == '0);
            head_data_reg   <= (count_next == '0) ? '0 : cell_data_next[0];
            entry_count_reg <= count_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.popped_valid    = popped_valid_reg;
    assign rsp.popped_data     = popped_data_reg;
    assign rsp.popped_priority = popped_prio_reg;
    assign rsp.status          = status_reg;
    assign rsp.queue_empty     = queue_empty_reg;
    assign rsp.head_data       = head_data_reg;
    assign rsp.entry_count     = entry_count_reg;

endmodule

// ===== rtl/core/spq_cell.sv =====
module spq_cell
    import spq_pkg::*;
#(
    parameter int DATA_BITS     = DEF_DATA_BITS,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
    input  logic                     clk,
    input  spq_ctrl_t                ctrl,
    input  logic                     occ,
    input  logic                     left_keep,
    input  logic [DATA_BITS-1:0]     left_data,
    input  logic [PRIORITY_BITS-1:0] left_prio,
    input  logic [DATA_BITS-1:0]     right_data,
    input  logic [PRIORITY_BITS-1:0] right_prio,
    input  logic [DATA_BITS-1:0]     new_data,
    input  logic [PRIORITY_BITS-1:0] new_prio,
    output logic                     keep,
    output logic [DATA_BITS-1:0]     data,
    output logic [PRIORITY_BITS-1:0] prio,
    output logic [DATA_BITS-1:0]     data_next
);

    logic [DATA_BITS-1:0]     data_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [PRIORITY_BITS-1:0] prio_next;

    // entry stays put on push when it is at or ahead of the new priority
    assign keep = occ && (prio_reg <= new_prio);
    assign data = data_reg;
    assign prio = prio_reg;

    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (ctrl.pop)
        begin
            data_next = right_data;
            prio_next = right_prio;
        end
        else if (ctrl.push && !keep)
        begin
            if (left_keep)
            begin
                data_next = new_data;
                prio_next = new_prio;
            end
            else
            begin
                data_next = left_data;
                prio_next = left_prio;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

endmodule

// ===== rtl/core/spq_checker.sv =====
module spq_checker
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1)
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic                  popped_valid,
    input logic [1:0]            status,
    input logic                  queue_empty,
    input logic [COUNT_BITS-1:0] entry_count
);

    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && popped_valid |-> status == STATUS_OK)
        else $error("popped item with error status");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> queue_empty == (entry_count == '0))
        else $error("empty flag disagrees with count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> entry_count <= COUNT_BITS'(QUEUE_DEPTH))
        else $error("entry count beyond depth");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_count))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
) u_spq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .popped_valid (rsp.popped_valid),
    .status       (rsp.status),
    .queue_empty  (rsp.queue_empty),
    .entry_count  (rsp.entry_count)
);

// ===== sim/testbench.sv =====
module testbench;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = DEF_QUEUE_DEPTH;
    localparam int DBITS        = DEF_DATA_BITS;
    localparam int PBITS        = DEF_PRIORITY_BITS;
    localparam int CBITS        = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS = 1780;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_PRINTS   = 30;

    typedef struct {
        logic             cmd;
        logic [DBITS-1:0] data;
        logic [PBITS-1:0] prio;
        bit               wait_drain;
    } queue_op_t;

    typedef struct {
        logic                   popped_valid;
        logic [DBITS-1:0]       popped_data;
        logic [PBITS-1:0]       popped_priority;
        logic [STATUS_BITS-1:0] status;
        logic                   queue_empty;
        logic [DBITS-1:0]       head_data;
        logic [CBITS-1:0]       entry_count;
    } queue_outcome_t;

    logic clk;
    logic rst_n;

    spq_req_if #(.DATA_BITS(DBITS), .PRIORITY_BITS(PBITS)) req_ch ();
    spq_rsp_if #(.DATA_BITS(DBITS), .PRIORITY_BITS(PBITS), .COUNT_BITS(CBITS)) rsp_ch ();

    sorted_priority_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // shadow of the sorted store
    logic [DBITS-1:0] shadow_data [DEPTH];
    logic [PBITS-1:0] shadow_prio [DEPTH];
    int               shadow_count;

    queue_op_t      pending_ops [$];
    queue_outcome_t outcome_fifo [$];

    int          mismatches;
    int          accepted_n;
    int          checked_n;
    int          push_n;
    int          pop_n;
    int          full_n;
    int          empty_n;
    int          send_gap;
    int          recv_gap;
    bit          hold_rsp;
    int unsigned cycle_no;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = CMD_PUSH;
        req_ch.item_data     = '0;
        req_ch.item_priority = '0;
        rsp_ch.ready         = 1'b0;
        hold_rsp             = 1'b0;
        send_gap             = 0;
        recv_gap             = 0;
        cycle_no             = 0;
        mismatches           = 0;
        accepted_n           = 0;
        checked_n            = 0;
        push_n               = 0;
        pop_n                = 0;
        full_n               = 0;
        empty_n              = 0;
        shadow_count         = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic apply_queue_op(input queue_op_t op, output queue_outcome_t r);
        int pos;
        r.popped_valid    = 1'b0;
        r.popped_data     = '0;
        r.popped_priority = '0;
        r.status          = STATUS_OK;
        if (op.cmd == CMD_PUSH)
        begin
            if (shadow_count >= DEPTH)
                r.status = STATUS_PUSH_FULL;
            else
            begin
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] <= op.prio)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_data[i] = shadow_data[i-1];
                    shadow_prio[i] = shadow_prio[i-1];
                end
                shadow_data[pos] = op.data;
                shadow_prio[pos] = op.prio;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
                r.status = STATUS_POP_EMPTY;
            else
            begin
                r.popped_valid    = 1'b1;
                r.popped_data     = shadow_data[0];
                r.popped_priority = shadow_prio[0];
                for (int i = 1; i < shadow_count; i++)
                begin
                    shadow_data[i-1] = shadow_data[i];
                    shadow_prio[i-1] = shadow_prio[i];
                end
                shadow_count--;
            end
        end
        r.queue_empty = (shadow_count == 0);
        r.head_data   = (shadow_count == 0) ? '0 : shadow_data[0];
        r.entry_count = shadow_count[CBITS-1:0];
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [DBITS-1:0] got,
                               input logic [DBITS-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      checked_n, name, got, want));
    endtask

    // driver
    always @(posedge clk)
    begin
        queue_outcome_t r;
        cycle_no <= cycle_no + 1;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!(req_ch.valid && !req_ch.ready))
        begin
            if (req_ch.valid)
            begin
                apply_queue_op(pending_ops[0], r);
                outcome_fifo.push_back(r);
                void'(pending_ops.pop_front());
                accepted_n++;
                if (r.status == STATUS_PUSH_FULL)
                    full_n++;
                else if (r.status == STATUS_POP_EMPTY)
                    empty_n++;
                else if (r.popped_valid)
                    pop_n++;
                else
                    push_n++;
                if (cycle_no[8:7] != 2'd0 && $urandom_range(0, 3) == 0)
                    send_gap = pick_gap();
            end
            if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_ops.size() > 0 &&
                     (!pending_ops[0].wait_drain || outcome_fifo.size() == 0))
            begin
                req_ch.valid         <= 1'b1;
                req_ch.cmd           <= pending_ops[0].cmd;
                req_ch.item_data     <= pending_ops[0].data;
                req_ch.item_priority <= pending_ops[0].prio;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        queue_outcome_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (outcome_fifo.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    want = outcome_fifo.pop_front();
                    check_field("popped_valid", DBITS'(rsp_ch.popped_valid),
                                DBITS'(want.popped_valid));
                    check_field("popped_data", rsp_ch.popped_data, want.popped_data);
                    check_field("popped_priority", DBITS'(rsp_ch.popped_priority),
                                DBITS'(want.popped_priority));
                    check_field("status", DBITS'(rsp_ch.status), DBITS'(want.status));
                    check_field("queue_empty", DBITS'(rsp_ch.queue_empty),
                                DBITS'(want.queue_empty));
                    check_field("head_data", rsp_ch.head_data, want.head_data);
                    check_field("entry_count", DBITS'(rsp_ch.entry_count),
                                DBITS'(want.entry_count));
                end
                checked_n++;
            end
            if (hold_rsp)
                rsp_ch.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (cycle_no[9:8] != 2'd1 && $urandom_range(0, 3) == 0)
                    recv_gap = pick_gap();
            end
        end
    end

    // long output back-pressure so the result register stays full and stalls the input
    initial
    begin
        while (accepted_n < 400)
            @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
        while (accepted_n < 1200)
            @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("timeout: %0d items accepted, %0d results checked", accepted_n, checked_n);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        queue_op_t   op;
        int          made;
        int          phase_len;
        int          bias;
        int          prio_kind;
        int unsigned pick;

        // pop on empty
        op = '{CMD_POP, '0, '0, 1'b0};
        pending_ops.push_back(op);
        // extremes of data and priority, ties at min, mid and max
        op = '{CMD_PUSH, 32'h7FFF_FFFF, 8'd255, 1'b0};
        pending_ops.push_back(op);
        op = '{CMD_PUSH, 32'h8000_0000, 8'd0, 1'b0};
        pending_ops.push_back(op);
        op = '{CMD_PUSH, 32'h0000_0000, 8'd128, 1'b0};
        pending_ops.push_back(op);
        op = '{CMD_PUSH, 32'hFFFF_FFFF, 8'd128, 1'b0};
        pending_ops.push_back(op);
        op = '{CMD_PUSH, 32'h5555_5555, 8'd128, 1'b0};
        pending_ops.push_back(op);
        op = '{CMD_PUSH, 32'hAAAA_AAAA, 8'd1, 1'b0};
        pending_ops.push_back(op);
        op = '{CMD_PUSH, 32'h1234_5678, 8'd255, 1'b0};
        pending_ops.push_back(op);
        op = '{CMD_PUSH, 32'h8765_4321, 8'd0, 1'b0};
        pending_ops.push_back(op);
        for (int i = 0; i < 8; i++)
        begin
            op = '{CMD_PUSH, 32'h100 + i, 8'(254 - 30 * i), 1'b0};
            pending_ops.push_back(op);
        end
        // push into full queue
        op = '{CMD_PUSH, 32'hDEAD_BEEF, 8'd0, 1'b0};
        pending_ops.push_back(op);
        for (int i = 0; i < 5; i++)
        begin
            op = '{CMD_POP, '0, '0, 1'b0};
            pending_ops.push_back(op);
        end

        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(20, 120);
            bias      = $urandom_range(0, 2);
            prio_kind = $urandom_range(0, 2);
            for (int k = 0; k < phase_len && made < RANDOM_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                case (bias)
                    0:       op.cmd = (pick < 85) ? CMD_PUSH : CMD_POP;
                    1:       op.cmd = (pick < 85) ? CMD_POP : CMD_PUSH;
                    default: op.cmd = (pick < 50) ? CMD_PUSH : CMD_POP;
                endcase
                op.data = $urandom;
                if ($urandom_range(0, 15) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       op.data = 32'h0000_0000;
                        1:       op.data = 32'hFFFF_FFFF;
                        2:       op.data = 32'h7FFF_FFFF;
                        default: op.data = 32'h8000_0000;
                    endcase
                end
                case (prio_kind)
                    0:       op.prio = PBITS'($urandom_range(0, 3));
                    1:       op.prio = PBITS'($urandom_range(0, 255));
                    default: op.prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                endcase
                op.wait_drain = (made % 300 == 0);
                pending_ops.push_back(op);
                made++;
            end
        end

        while (!rst_n || pending_ops.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (outcome_fifo.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (outcome_fifo.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", outcome_fifo.size()));

        $display("%0d items: %0d pushes stored, %0d pops served", accepted_n, push_n, pop_n);
        $display("%0d pushes on a full queue, %0d pops on an empty queue, %0d mismatches",
                 full_n, empty_n, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
